// ===== design/tzpt_pkg.sv =====
package tzpt_pkg;

	// fraction bits of the tangent inputs and of the sensor-frame point
	localparam int TAN_FRAC = 13;

	// configuration port
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	// result coordinates
	localparam int OUT_W   = 18;
	localparam int OUT_MAX = 131071;
	localparam int OUT_MIN = -131072;

	// tangent input width
	localparam int TAN_W = 16;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_YAW_COS   = 3'd0,
		REG_YAW_SIN   = 3'd1,
		REG_PITCH_COS = 3'd2,
		REG_PITCH_SIN = 3'd3,
		REG_MOUNT_X   = 3'd4,
		REG_MOUNT_Y   = 3'd5,
		REG_MOUNT_Z   = 3'd6
	} cfg_reg_t;

endpackage

// ===== design/tzpt_yaw.sv =====
// Stages 1 to 3: sensor-frame point, yaw products, yaw sums rounded to Q.13.
module tzpt_yaw #(
	parameter int D = 14,
	parameter int F = 14,
	localparam int TW   = (F + 2 > 16) ? F + 2 : 16,
	localparam int SYW  = D + 17,
	localparam int DCW  = D + 1 + TW,
	localparam int PW   = SYW + TW,
	localparam int W3   = PW + 1,
	localparam int XY_W = W3 - F
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [D-1:0]                        distance,
	input  logic signed [tzpt_pkg::TAN_W-1:0]   tan_lateral,
	input  logic signed [tzpt_pkg::TAN_W-1:0]   tan_vertical,
	input  logic                                side_left,
	input  logic signed [TW-1:0]                yaw_cos,
	input  logic signed [TW-1:0]                yaw_sin,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [XY_W-1:0]              out_xy,
	output logic signed [XY_W-1:0]              out_yy,
	output logic signed [SYW-1:0]               out_sz,
	output logic                                out_nz,
	output logic                                out_left
);
	import tzpt_pkg::*;

	localparam logic signed [W3-1:0] HALF = W3'(1) << (F - 1);

	logic                   v_s1, v_s2, v_s3;
	logic                   rdy_s1, rdy_s2, rdy_s3;
	logic                   nz_s1, nz_s2, nz_s3;
	logic                   left_s1, left_s2, left_s3;
	logic [D-1:0]           d_s1;
	logic signed [SYW-1:0]  sy_s1, sz_s1, sz_s2, sz_s3;
	logic signed [DCW-1:0]  dc_s2, ds_s2;
	logic signed [PW-1:0]   sys_s2, syc_s2;
	logic signed [XY_W-1:0] xy_s3, yy_s3;
	logic signed [W3-1:0]   xsum, ysum;

	// a stage takes a new transfer when empty or when its successor moves
	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// stage 1: d*tan products
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			d_s1    <= distance;
			nz_s1   <= (distance != '0);
			left_s1 <= side_left;
			sy_s1   <= $signed({1'b0, distance}) * tan_lateral;
			sz_s1   <= $signed({1'b0, distance}) * tan_vertical;
		end
	end

	// stage 2: yaw products; x of the sensor point is d << 13, shift applied later
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			dc_s2   <= $signed({1'b0, d_s1}) * yaw_cos;
			ds_s2   <= $signed({1'b0, d_s1}) * yaw_sin;
			sys_s2  <= sy_s1 * yaw_sin;
			syc_s2  <= sy_s1 * yaw_cos;
			sz_s2   <= sz_s1;
			nz_s2   <= nz_s1;
			left_s2 <= left_s1;
		end
	end

	// stage 3: yaw sums, round half up back to Q.13
	always_comb begin
		xsum = (W3'(dc_s2) <<< TAN_FRAC) - W3'(sys_s2) + HALF;
		ysum = (W3'(ds_s2) <<< TAN_FRAC) + W3'(syc_s2) + HALF;
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			xy_s3   <= XY_W'(xsum >>> F);
			yy_s3   <= XY_W'(ysum >>> F);
			sz_s3   <= sz_s2;
			nz_s3   <= nz_s2;
			left_s3 <= left_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_xy    = xy_s3;
	assign out_yy    = yy_s3;
	assign out_sz    = sz_s3;
	assign out_nz    = nz_s3;
	assign out_left  = left_s3;

endmodule

// ===== design/tzpt_pitch.sv =====
// Stages 4 and 5: pitch products, then pitch sums rounded to whole mm.
module tzpt_pitch #(
	parameter int D = 14,
	parameter int F = 14,
	localparam int TW   = (F + 2 > 16) ? F + 2 : 16,
	localparam int SYW  = D + 17,
	localparam int XY_W = SYW + TW + 1 - F,
	localparam int YW   = XY_W + 1 - tzpt_pkg::TAN_FRAC,
	localparam int PSW  = XY_W + TW + 1,
	localparam int RW   = PSW - tzpt_pkg::TAN_FRAC - F
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [XY_W-1:0] xy,
	input  logic signed [XY_W-1:0] yy,
	input  logic signed [SYW-1:0]  sz,
	input  logic                   nz,
	input  logic                   left,
	input  logic signed [TW-1:0]   pitch_cos,
	input  logic signed [TW-1:0]   pitch_sin,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [RW-1:0]   out_rx,
	output logic signed [YW-1:0]   out_ry,
	output logic signed [RW-1:0]   out_rz,
	output logic                   out_nz,
	output logic                   out_left
);
	import tzpt_pkg::*;

	localparam logic signed [XY_W:0]  YHALF = (XY_W + 1)'(1) << (TAN_FRAC - 1);
	localparam logic signed [PSW-1:0] PHALF = PSW'(1) << (TAN_FRAC + F - 1);

	logic                        v_s4, v_s5;
	logic                        rdy_s4, rdy_s5;
	logic                        nz_s4, nz_s5, left_s4, left_s5;
	logic signed [XY_W+TW-1:0]   xc_s4, xs_s4;
	logic signed [SYW+TW-1:0]    zc_s4, zs_s4;
	logic signed [YW-1:0]        ry_s4, ry_s5;
	logic signed [RW-1:0]        rx_s5, rz_s5;
	logic signed [XY_W:0]        ysum;
	logic signed [PSW-1:0]       xsum, zsum;

	assign rdy_s5   = !v_s5 || out_ready;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign in_ready = rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s4) v_s4 <= in_valid;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// y needs no pitch term: round it to whole mm here
	assign ysum = (XY_W + 1)'(yy) + YHALF;

	// stage 4: pitch products
	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			xc_s4   <= xy * pitch_cos;
			xs_s4   <= xy * pitch_sin;
			zc_s4   <= sz * pitch_cos;
			zs_s4   <= sz * pitch_sin;
			ry_s4   <= YW'(ysum >>> TAN_FRAC);
			nz_s4   <= nz;
			left_s4 <= left;
		end
	end

	// stage 5: x' = xy*pc + z*ps, z' = z*pc - xy*ps, round half up to mm
	always_comb begin
		xsum = PSW'(xc_s4) + PSW'(zs_s4) + PHALF;
		zsum = PSW'(zc_s4) - PSW'(xs_s4) + PHALF;
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			rx_s5   <= RW'(xsum >>> (TAN_FRAC + F));
			rz_s5   <= RW'(zsum >>> (TAN_FRAC + F));
			ry_s5   <= ry_s4;
			nz_s5   <= nz_s4;
			left_s5 <= left_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_rx    = rx_s5;
	assign out_ry    = ry_s5;
	assign out_rz    = rz_s5;
	assign out_nz    = nz_s5;
	assign out_left  = left_s5;

endmodule

// ===== design/tzpt_out.sv =====
// Stage 6: mounting offset, saturation, no-return masking; holds the result register.
module tzpt_out #(
	parameter int RW = 24,
	parameter int YW = 22,
	localparam int MW = (RW > YW) ? RW : YW,
	localparam int SW = ((MW > tzpt_pkg::CFG_W + 1) ? MW : tzpt_pkg::CFG_W + 1) + 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [RW-1:0]                rx,
	input  logic signed [YW-1:0]                ry,
	input  logic signed [RW-1:0]                rz,
	input  logic                                nz,
	input  logic                                left,
	input  logic signed [tzpt_pkg::CFG_W-1:0]   mount_x,
	input  logic signed [tzpt_pkg::CFG_W-1:0]   mount_y,
	input  logic signed [tzpt_pkg::CFG_W-1:0]   mount_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [tzpt_pkg::OUT_W-1:0]   point_x,
	output logic signed [tzpt_pkg::OUT_W-1:0]   point_y,
	output logic signed [tzpt_pkg::OUT_W-1:0]   point_z,
	output logic                                point_valid
);
	import tzpt_pkg::*;

	localparam logic signed [SW-1:0] SAT_HI = SW'(OUT_MAX);
	localparam logic signed [SW-1:0] SAT_LO = SW'(OUT_MIN);

	logic                    v_s6, rdy_s6;
	logic signed [SW-1:0]    sum_x, sum_y, sum_z, off_y;
	logic signed [OUT_W-1:0] x_s6, y_s6, z_s6;
	logic                    nz_s6;

	function automatic logic signed [OUT_W-1:0] sat(input logic signed [SW-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > SAT_HI) r = OUT_W'(SAT_HI);
		else if (v < SAT_LO) r = OUT_W'(SAT_LO);
		else r = OUT_W'(v);
		return r;
	endfunction

	assign rdy_s6   = !v_s6 || out_ready;
	assign in_ready = rdy_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (rdy_s6) begin
			v_s6 <= in_valid;
		end
	end

	// y offset sign follows the sensor side
	always_comb begin
		off_y = left ? SW'(mount_y) : -SW'(mount_y);
		sum_x = SW'(rx) + SW'(mount_x);
		sum_y = SW'(ry) + off_y;
		sum_z = SW'(rz) + SW'(mount_z);
	end

	// no return gives zero coordinates
	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			x_s6  <= nz ? sat(sum_x) : '0;
			y_s6  <= nz ? sat(sum_y) : '0;
			z_s6  <= nz ? sat(sum_z) : '0;
			nz_s6 <= nz;
		end
	end

	assign out_valid   = v_s6;
	assign point_x     = x_s6;
	assign point_y     = y_s6;
	assign point_z     = z_s6;
	assign point_valid = nz_s6;

endmodule

// ===== design/tof_zone_point_transform.sv =====
// Turns one time-of-flight zone (distance in mm, Q2.13 lateral and vertical
// tangents, sensor side) into a robot-frame point: the sensor point
// (d, d*tan_lateral, d*tan_vertical) is rotated by yaw, then pitch, using the
// Q1.14 cosine/sine registers, rounded half up to mm, offset by the mounting
// position (y offset negated for the right sensor) and saturated to 18 bits.
// A zero distance yields point_valid = 0 with zero coordinates. The datapath
// is a six-stage pipeline (sensor point, yaw products, yaw sums, pitch
// products, pitch sums, offset/saturate) that takes one zone every cycle
// unless it is stalled. Each stage holds its data while the next is full, so
// back-pressure on the result channel stalls the pipe without loss and
// bubbles are squeezed out. Write configuration only while no zone is in
// flight; register indexes 0..6 follow the order yaw_cos, yaw_sin,
// pitch_cos, pitch_sin, mount_x, mount_y, mount_z; other indexes are ignored.
module tof_zone_point_transform #(
	parameter int DISTANCE_BITS  = 14,
	parameter int TRIG_FRAC_BITS = 14,
	localparam int TW   = (TRIG_FRAC_BITS + 2 > 16) ? TRIG_FRAC_BITS + 2 : 16,
	localparam int SYW  = DISTANCE_BITS + 17,
	localparam int XY_W = SYW + TW + 1 - TRIG_FRAC_BITS,
	localparam int YW   = XY_W + 1 - tzpt_pkg::TAN_FRAC,
	localparam int RW   = XY_W + TW + 1 - tzpt_pkg::TAN_FRAC - TRIG_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_wr_en,
	input  logic [tzpt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tzpt_pkg::CFG_W-1:0]          cfg_wdata,
	// zone input
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [DISTANCE_BITS-1:0]            distance,
	input  logic signed [tzpt_pkg::TAN_W-1:0]   tan_lateral,
	input  logic signed [tzpt_pkg::TAN_W-1:0]   tan_vertical,
	input  logic                                side_left,
	// point output
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [tzpt_pkg::OUT_W-1:0]   point_x,
	output logic signed [tzpt_pkg::OUT_W-1:0]   point_y,
	output logic signed [tzpt_pkg::OUT_W-1:0]   point_z,
	output logic                                point_valid
);
	import tzpt_pkg::*;

	localparam logic signed [TW-1:0] TRIG_ONE = TW'(1) << TRIG_FRAC_BITS;

	logic signed [TW-1:0]    yaw_cos_q, yaw_sin_q, pitch_cos_q, pitch_sin_q;
	logic signed [CFG_W-1:0] mount_x_q, mount_y_q, mount_z_q;
	logic signed [TW-1:0]    wdata_trig;

	logic                   yv, yrdy, pv, prdy;
	logic signed [XY_W-1:0] xy, yy;
	logic signed [SYW-1:0]  sz;
	logic                   y_nz, y_left, p_nz, p_left;
	logic signed [RW-1:0]   rx, rz;
	logic signed [YW-1:0]   ry;

	assign wdata_trig = TW'($signed(cfg_wdata));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_cos_q   <= TRIG_ONE;
			yaw_sin_q   <= '0;
			pitch_cos_q <= TRIG_ONE;
			pitch_sin_q <= '0;
			mount_x_q   <= '0;
			mount_y_q   <= '0;
			mount_z_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_YAW_COS:   yaw_cos_q   <= wdata_trig;
				REG_YAW_SIN:   yaw_sin_q   <= wdata_trig;
				REG_PITCH_COS: pitch_cos_q <= wdata_trig;
				REG_PITCH_SIN: pitch_sin_q <= wdata_trig;
				REG_MOUNT_X:   mount_x_q   <= $signed(cfg_wdata);
				REG_MOUNT_Y:   mount_y_q   <= $signed(cfg_wdata);
				REG_MOUNT_Z:   mount_z_q   <= $signed(cfg_wdata);
				default: ;
			endcase
		end
	end

	// stages 1-3
	tzpt_yaw #(
		.D (DISTANCE_BITS),
		.F (TRIG_FRAC_BITS)
	) u_yaw (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.distance     (distance),
		.tan_lateral  (tan_lateral),
		.tan_vertical (tan_vertical),
		.side_left    (side_left),
		.yaw_cos      (yaw_cos_q),
		.yaw_sin      (yaw_sin_q),
		.out_valid    (yv),
		.out_ready    (yrdy),
		.out_xy       (xy),
		.out_yy       (yy),
		.out_sz       (sz),
		.out_nz       (y_nz),
		.out_left     (y_left)
	);

	// stages 4-5
	tzpt_pitch #(
		.D (DISTANCE_BITS),
		.F (TRIG_FRAC_BITS)
	) u_pitch (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (yv),
		.in_ready  (yrdy),
		.xy        (xy),
		.yy        (yy),
		.sz        (sz),
		.nz        (y_nz),
		.left      (y_left),
		.pitch_cos (pitch_cos_q),
		.pitch_sin (pitch_sin_q),
		.out_valid (pv),
		.out_ready (prdy),
		.out_rx    (rx),
		.out_ry    (ry),
		.out_rz    (rz),
		.out_nz    (p_nz),
		.out_left  (p_left)
	);

	// stage 6
	tzpt_out #(
		.RW (RW),
		.YW (YW)
	) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (pv),
		.in_ready    (prdy),
		.rx          (rx),
		.ry          (ry),
		.rz          (rz),
		.nz          (p_nz),
		.left        (p_left),
		.mount_x     (mount_x_q),
		.mount_y     (mount_y_q),
		.mount_z     (mount_z_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.point_valid (point_valid)
	);

endmodule

// ===== dv/tof_zone_point_transform_test.sv =====
`timescale 1ns / 100ps

module tof_zone_point_transform_test;
	import tzpt_pkg::*;

	localparam int DIST_W        = 14;
	localparam int TRIG_FRAC     = 14;
	localparam int SETTLE_CYCLES = 12;
	localparam longint RUN_LIMIT_NS = 64'd6_000_000;

	// index past the end of the register list, writes to it are dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic signed [TAN_W-1:0] TAN_HI = 16'sh7fff;
	localparam logic signed [TAN_W-1:0] TAN_LO = 16'sh8000;
	localparam logic [CFG_W-1:0] Q14_ONE     = 16'h4000;
	localparam logic [CFG_W-1:0] Q14_NEG_ONE = 16'hc000;
	localparam logic [CFG_W-1:0] S16_MAX     = 16'h7fff;
	localparam logic [CFG_W-1:0] S16_MIN     = 16'h8000;

	typedef struct packed {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic signed [OUT_W-1:0] z;
		logic                    hit;
	} zone_point_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         cfg_wr_en;
	logic [CFG_IDX_W-1:0]         cfg_index;
	logic [CFG_W-1:0]             cfg_wdata;
	logic                         in_valid;
	logic                         in_ready;
	logic [DIST_W-1:0]            distance;
	logic signed [TAN_W-1:0]      tan_lateral;
	logic signed [TAN_W-1:0]      tan_vertical;
	logic                         side_left;
	logic                         out_valid;
	logic                         out_ready;
	logic signed [OUT_W-1:0]      point_x;
	logic signed [OUT_W-1:0]      point_y;
	logic signed [OUT_W-1:0]      point_z;
	logic                         point_valid;

	// mirror of the mounting registers
	longint cur_yaw_cos, cur_yaw_sin, cur_pitch_cos, cur_pitch_sin;
	longint cur_mount_x, cur_mount_y, cur_mount_z;

	zone_point_t pending_points[$];
	int          mismatches;
	bit          no_idle;
	int          out_stall;

	tof_zone_point_transform #(
		.DISTANCE_BITS (DIST_W),
		.TRIG_FRAC_BITS(TRIG_FRAC)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.distance    (distance),
		.tan_lateral (tan_lateral),
		.tan_vertical(tan_vertical),
		.side_left   (side_left),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.point_valid (point_valid)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// round half up, floor shift
	function automatic longint round_half_up(longint v, int sh);
		return (v + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	function automatic logic signed [OUT_W-1:0] clamp_mm(longint v);
		if (v > OUT_MAX)
			return OUT_W'(OUT_MAX);
		if (v < OUT_MIN)
			return OUT_W'(OUT_MIN);
		return v[OUT_W-1:0];
	endfunction

	// yaw about z, pitch about y, then mounting offset
	function automatic zone_point_t transform_zone(logic [DIST_W-1:0] d,
			logic signed [TAN_W-1:0] tl, logic signed [TAN_W-1:0] tv, logic left);
		longint dd, sx, sy, sz, xy, yy, rx, rz, oy;
		zone_point_t p;
		p = '0;
		if (d == '0)
			return p;
		dd = longint'(d);
		sx = dd <<< TAN_FRAC;
		sy = dd * longint'(tl);
		sz = dd * longint'(tv);
		xy = round_half_up(sx * cur_yaw_cos - sy * cur_yaw_sin, TRIG_FRAC);
		yy = round_half_up(sx * cur_yaw_sin + sy * cur_yaw_cos, TRIG_FRAC);
		rx = xy * cur_pitch_cos + sz * cur_pitch_sin;
		rz = sz * cur_pitch_cos - xy * cur_pitch_sin;
		oy = left ? cur_mount_y : -cur_mount_y;
		p.x   = clamp_mm(round_half_up(rx, TAN_FRAC + TRIG_FRAC) + cur_mount_x);
		p.y   = clamp_mm(round_half_up(yy, TAN_FRAC) + oy);
		p.z   = clamp_mm(round_half_up(rz, TAN_FRAC + TRIG_FRAC) + cur_mount_z);
		p.hit = 1'b1;
		return p;
	endfunction

	// mostly short gaps, some long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic signed [TAN_W-1:0] rand_tangent();
		if ($urandom_range(0, 1))
			return 16'($urandom());
		return 16'($urandom_range(0, 8192) - 4096);
	endfunction

	function automatic logic [DIST_W-1:0] rand_distance();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return DIST_MAX;
		if (r == 2)
			return DIST_W'(1);
		return DIST_W'($urandom_range(1, 2**DIST_W - 1));
	endfunction

	function automatic logic [CFG_W-1:0] rand_trig();
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom());
		return 16'($urandom_range(0, 32768) - 16384);
	endfunction

	function automatic logic [CFG_W-1:0] rand_mount();
		case ($urandom_range(0, 9))
			0: return S16_MAX;
			1: return S16_MIN;
			2: return 16'($urandom());
			default: return 16'($urandom_range(0, 4000) - 2000);
		endcase
	endfunction

	// one register write, mirrored into the predictor
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		longint v;
		v = longint'($signed(val));
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(posedge clk);
		case (idx)
			REG_YAW_COS:   cur_yaw_cos   = v;
			REG_YAW_SIN:   cur_yaw_sin   = v;
			REG_PITCH_COS: cur_pitch_cos = v;
			REG_PITCH_SIN: cur_pitch_sin = v;
			REG_MOUNT_X:   cur_mount_x   = v;
			REG_MOUNT_Y:   cur_mount_y   = v;
			REG_MOUNT_Z:   cur_mount_z   = v;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic write_all(logic [CFG_W-1:0] yc, logic [CFG_W-1:0] ys,
			logic [CFG_W-1:0] pc, logic [CFG_W-1:0] ps, logic [CFG_W-1:0] mx,
			logic [CFG_W-1:0] my, logic [CFG_W-1:0] mz);
		write_reg(REG_YAW_COS, yc);
		write_reg(REG_YAW_SIN, ys);
		write_reg(REG_PITCH_COS, pc);
		write_reg(REG_PITCH_SIN, ps);
		write_reg(REG_MOUNT_X, mx);
		write_reg(REG_MOUNT_Y, my);
		write_reg(REG_MOUNT_Z, mz);
	endtask

	// one zone transfer; called and left at a falling edge with valid low
	task automatic send_zone(logic [DIST_W-1:0] d, logic signed [TAN_W-1:0] tl,
			logic signed [TAN_W-1:0] tv, logic left);
		int gap;
		gap = pick_gap();
		repeat (gap) @(negedge clk);
		distance     = d;
		tan_lateral  = tl;
		tan_vertical = tv;
		side_left    = left;
		in_valid     = 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_points.insert(pending_points.size(), transform_zone(d, tl, tv, left));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// pipe empty and settled, safe to write registers
	task automatic wait_drained();
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// reset register values: field extremes, both sides, no return
	task automatic test_default_registers();
		send_zone(DIST_MAX, 16'sd0, 16'sd0, 1'b1);
		send_zone(DIST_W'(1), 16'sd0, 16'sd0, 1'b0);
		send_zone('0, TAN_HI, TAN_LO, 1'b1);
		send_zone(DIST_MAX, TAN_HI, TAN_LO, 1'b1);
		send_zone(DIST_MAX, TAN_LO, TAN_HI, 1'b0);
		send_zone(DIST_W'(8192), 16'sd4096, -16'sd4096, 1'b1);
		send_zone(DIST_W'(1), -16'sd1, 16'sd1, 1'b0);
	endtask

	// quarter turns, trig outside its range, mount extremes, saturation
	task automatic test_register_extremes();
		wait_drained();
		write_all(16'h0000, Q14_ONE, Q14_NEG_ONE, 16'h0000, S16_MAX, S16_MIN, S16_MAX);
		// dropped write to an index past the list
		write_reg(REG_UNUSED, 16'h1234);
		send_zone(DIST_MAX, TAN_HI, TAN_LO, 1'b1);
		send_zone(DIST_MAX, TAN_LO, TAN_HI, 1'b0);
		send_zone(DIST_W'(100), 16'sd8192, -16'sd8192, 1'b0);
		wait_drained();
		write_all(S16_MAX, S16_MIN, S16_MIN, S16_MAX, S16_MIN, S16_MAX, S16_MIN);
		send_zone(DIST_MAX, TAN_HI, TAN_HI, 1'b1);
		send_zone(DIST_MAX, TAN_LO, TAN_LO, 1'b0);
		send_zone('0, TAN_HI, TAN_HI, 1'b0);
		send_zone(DIST_W'(3), -16'sd3, 16'sd5, 1'b1);
		wait_drained();
		write_all(Q14_NEG_ONE, 16'h0000, 16'h0000, Q14_NEG_ONE, 16'h0000, 16'h0000,
			16'h0000);
		send_zone(DIST_MAX, TAN_HI, TAN_LO, 1'b1);
		send_zone(DIST_W'(5000), -16'sd1000, 16'sd2000, 1'b0);
	endtask

	// random mountings, each followed by a stream of random zones
	task automatic test_random_zones(int phases, int per_phase);
		logic [CFG_W-1:0] quad_cos[4];
		logic [CFG_W-1:0] quad_sin[4];
		int qy, qp;
		quad_cos = '{Q14_ONE, 16'h0000, Q14_NEG_ONE, 16'h0000};
		quad_sin = '{16'h0000, Q14_ONE, 16'h0000, Q14_NEG_ONE};
		for (int ph = 0; ph < phases; ph++) begin
			wait_drained();
			no_idle = 1'b0;
			if ($urandom_range(0, 3) == 0) begin
				qy = $urandom_range(0, 3);
				qp = $urandom_range(0, 3);
				write_all(quad_cos[qy], quad_sin[qy], quad_cos[qp], quad_sin[qp],
					rand_mount(), rand_mount(), rand_mount());
			end else begin
				write_all(rand_trig(), rand_trig(), rand_trig(), rand_trig(),
					rand_mount(), rand_mount(), rand_mount());
			end
			if ($urandom_range(0, 2) == 0)
				write_reg(REG_UNUSED, 16'($urandom()));
			// some phases run back to back on the input side
			no_idle = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < per_phase; i++)
				send_zone(rand_distance(), rand_tangent(), rand_tangent(),
					1'($urandom_range(0, 1)));
		end
		no_idle = 1'b0;
	endtask

	task automatic compare_field(string label, longint want, longint got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 50)
				$display("%0t %s mismatch: expected %0d, actual %0d", $time, label, want, got);
		end
	endtask

	// result side back-pressure
	initial begin
		out_ready = 1'b0;
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (out_stall > 0) begin
				out_ready = 1'b0;
				out_stall--;
			end else begin
				out_ready = 1'b1;
				if ($urandom_range(0, 99) < 30)
					out_stall = pick_gap();
			end
		end
	end

	// check each point transfer against the oldest prediction
	always @(posedge clk) begin
		zone_point_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 50)
					$display("%0t unexpected point: none pending, actual %0d %0d %0d %0d",
						$time, point_x, point_y, point_z, point_valid);
			end else begin
				want = pending_points.pop_front();
				compare_field("point_x", want.x, point_x);
				compare_field("point_y", want.y, point_y);
				compare_field("point_z", want.z, point_z);
				compare_field("point_valid", want.hit, point_valid);
			end
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		cfg_wr_en     = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		in_valid      = 1'b0;
		distance      = '0;
		tan_lateral   = '0;
		tan_vertical  = '0;
		side_left     = 1'b0;
		no_idle       = 1'b0;
		mismatches    = 0;
		cur_yaw_cos   = 64'sd1 <<< TRIG_FRAC;
		cur_pitch_cos = 64'sd1 <<< TRIG_FRAC;
		cur_yaw_sin   = 0;
		cur_pitch_sin = 0;
		cur_mount_x   = 0;
		cur_mount_y   = 0;
		cur_mount_z   = 0;
		arst_n        = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_default_registers();
		test_register_extremes();
		test_random_zones(12, 160);

		wait_drained();
		if (mismatches == 0 && pending_points.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
